// ===== rtl/core/crps_pkg.sv =====
// Shared types and constants for the seat sampler.
package crps_pkg;

	localparam int U_W        = 32;
	localparam int ALPHA_W    = 32;
	localparam int ECNT_W     = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_W     = 16;
	localparam int SUM_W      = 33;
	localparam int PROD_W     = 64;
	localparam int IDX_OUT_W  = 10;
	localparam int TOT_OUT_W  = 11;
	localparam int OUT_PAD_W  = 3;
	localparam int OUT_DATA_W = IDX_OUT_W + TOT_OUT_W + OUT_PAD_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 32'h0001_0000;
	localparam logic [ECNT_W-1:0]  ECNT_RST  = 11'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_WALK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic sum_lt_c;
		logic c_lt_sum;
	} alu_flags_t;

endpackage

// ===== rtl/core/crps_mul.sv =====
// Registered 32x32 multiplier for the scaled sample product.
module crps_mul
	import crps_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [U_W-1:0]    a,
	input  logic [U_W-1:0]    b,
	output logic [PROD_W-1:0] p
);

	logic [PROD_W-1:0] p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign p = p_s1;

endmodule

// ===== rtl/core/crps_alu.sv =====
// Shared adder with two-way compare against a third operand.
module crps_alu
	import crps_pkg::*;
(
	input  logic [SUM_W-1:0] a,
	input  logic [SUM_W-1:0] b,
	input  logic [SUM_W-1:0] c,
	output logic [SUM_W-1:0] sum,
	output alu_flags_t       flags
);

	assign sum            = a + b;
	assign flags.sum_lt_c = (sum < c);
	assign flags.c_lt_sum = (c < sum);

endmodule

// ===== rtl/core/crps_sizes.sv =====
// Per-subset count memory, one write and one registered read port.
module crps_sizes #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/dirichlet_process_seat_sampler.sv =====
// Top level of the Chinese restaurant process seat sampler.
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tdata[31:0] = u_sample
// m_*       out  tvalid/tready     tdata = subset_index, subset_total; tlast = last_element
// cfg_*     in   we                index 0 alpha, 1 element_count
//
// An element that opens a subset passes the accept, multiply, compare and output steps;
// one that joins subset j also walks subsets 0 to j before output: the count memory is
// walked one subset a cycle through the shared adder/comparator. Reset restores control
// and configuration state; the count memory needs no clearing. A stalled output holds
// the sequencer in its final step until the result register frees up.
module dirichlet_process_seat_sampler
	import crps_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [U_W-1:0]        s_tdata,   // [31:0] u_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] subset_index, [20:10] subset_total
	output logic                  m_tlast
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int LEN_W = (IDX_W + 1 > ECNT_W) ? IDX_W + 1 : ECNT_W;

	state_t state_q, state_d;

	logic [ALPHA_W-1:0]  alpha_q;
	logic [ECNT_W-1:0]   ecnt_q;
	logic [IDX_W-1:0]    pos_q;
	logic [CNT_W-1:0]    open_q;
	logic [U_W-1:0]      u_q;
	logic [SUM_W-1:0]    s_q;
	logic [SUM_W-1:0]    q_q;
	logic [SUM_W-1:0]    x_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    idx_q;

	logic                m_valid_q;
	logic [IDX_OUT_W-1:0] m_idx_q;
	logic [TOT_OUT_W-1:0] m_tot_q;
	logic                m_last_q;

	logic [PROD_W-1:0]   prod;
	logic                mul_en;
	logic [SUM_W-1:0]    alu_a, alu_b, alu_c, alu_sum;
	alu_flags_t          alu_flags;

	logic                rd_en, wr_en;
	logic [IDX_W-1:0]    rd_addr, wr_addr;
	logic [CNT_W-1:0]    rd_data, wr_data;

	logic                in_acc, out_free, open_new, walk_end, last_elem;
	logic [LEN_W-1:0]    len_raw, len_max, len_eff;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign open_new = (open_q == '0) || alu_flags.sum_lt_c;
	assign walk_end = alu_flags.c_lt_sum || ((CNT_W'(j_q) + CNT_W'(1)) == open_q);

	assign len_raw   = LEN_W'(ecnt_q);
	assign len_max   = LEN_W'(MAX_ELEMENTS);
	assign len_eff   = (len_raw == '0) ? LEN_W'(1) :
	                   (len_raw > len_max) ? len_max : len_raw;
	assign last_elem = ((LEN_W'(pos_q) + LEN_W'(1)) >= len_eff);

	crps_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (u_q),
		.b   (s_q[U_W-1:0]),
		.p   (prod)
	);

	crps_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.c     (alu_c),
		.sum   (alu_sum),
		.flags (alu_flags)
	);

	crps_sizes #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (IDX_W),
		.DW    (CNT_W)
	) u_sizes (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_MUL;
			ST_MUL:  state_d = ST_CMP;
			ST_CMP:  state_d = open_new ? ST_OUT : ST_WALK;
			ST_WALK: if (walk_end) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_en   = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		alu_c    = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL:  mul_en = 1'b1;
			ST_CMP: begin
				alu_a = SUM_W'(prod[PROD_W-1:U_W]);
				alu_b = s_q[SUM_W-1] ? SUM_W'(u_q) : '0;
				alu_c = SUM_W'(alpha_q);
				if (open_new) begin
					wr_en   = 1'b1;
					wr_addr = open_q[IDX_W-1:0];
					wr_data = CNT_W'(1);
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_WALK: begin
				alu_a = x_q;
				alu_b = SUM_W'(rd_data) << FRAC_W;
				alu_c = q_q;
				if (walk_end) begin
					wr_en   = 1'b1;
					wr_addr = j_q;
					wr_data = rd_data + CNT_W'(1);
				end else begin
					rd_en   = 1'b1;
					rd_addr = j_q + IDX_W'(1);
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			alpha_q   <= ALPHA_RST;
			ecnt_q    <= ECNT_RST;
			pos_q     <= '0;
			open_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_ALPHA) begin
					alpha_q <= cfg_data[ALPHA_W-1:0];
				end else if (cfg_index == CFG_COUNT) begin
					ecnt_q <= cfg_data[ECNT_W-1:0];
				end
			end
			if (state_q == ST_CMP && open_new) begin
				open_q <= open_q + CNT_W'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
				if (last_elem) begin
					pos_q  <= '0;
					open_q <= '0;
				end else begin
					pos_q <= pos_q + IDX_W'(1);
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_q <= s_tdata;
			s_q <= SUM_W'(alpha_q) + (SUM_W'(pos_q) << FRAC_W);
		end
		if (state_q == ST_CMP) begin
			q_q <= alu_sum;
			x_q <= SUM_W'(alpha_q);
			j_q <= '0;
			if (open_new) begin
				idx_q <= open_q[IDX_W-1:0];
			end
		end
		if (state_q == ST_WALK) begin
			if (walk_end) begin
				idx_q <= j_q;
			end else begin
				x_q <= alu_sum;
				j_q <= j_q + IDX_W'(1);
			end
		end
		if (state_q == ST_OUT && out_free) begin
			m_idx_q  <= IDX_OUT_W'(idx_q);
			m_tot_q  <= TOT_OUT_W'(open_q);
			m_last_q <= last_elem;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {OUT_PAD_W'(0), m_tot_q, m_idx_q};
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_open_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (open_q <= CNT_W'(pos_q)))
		else $error("open subsets exceed position");

	a_draw_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && pos_q == '0) |-> (open_q == '0))
		else $error("subsets open at draw start");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CNT_W'(j_q) < open_q))
		else $error("walk beyond open subsets");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (m_valid_q && state_q == ST_IDLE))
		else $error("result not loaded");
`endif

endmodule
